// File: hw/rtl/stq_pkg.sv
package stq_pkg;

   // Function codes of a request
   localparam logic [2:0] FUNC_INSERT = 3'd0;
   localparam logic [2:0] FUNC_CANCEL = 3'd1;
   localparam logic [2:0] FUNC_RESET  = 3'd2;
   localparam logic [2:0] FUNC_FIRE   = 3'd3;
   localparam logic [2:0] FUNC_TICK   = 3'd4;

   // Response status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NONE_DUE  = 2'd3;

   localparam logic [15:0] ID_FIRST = 16'd1;
   localparam logic [15:0] ID_LAST  = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] delay_ms;
      logic [15:0] timer_id;
      logic [31:0] handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        fired;
      logic [15:0] out_id;
      logic [31:0] out_handle;
      logic [4:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [31:0] deadline;
      logic [15:0] id;
      logic [31:0] handle;
   } entry_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_SCAN,
      CELL_REMOVE,
      CELL_POP,
      CELL_INSERT
   } cell_op_type;

   // Broadcast from the sequencer to every cell
   typedef struct packed {
      cell_op_type op;
      logic [15:0] tid;
      entry_type   entry;
   } cell_cmd_type;

   // What one cell shows its neighbors
   typedef struct packed {
      entry_type entry;
      logic      le;
      logic      prior;
      entry_type carry;
   } cell_link_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_DECIDE,
      ST_REMOVE,
      ST_PLACE,
      ST_INSERT,
      ST_TICK,
      ST_RESP
   } state_type;

endpackage

// File: hw/rtl/stq_cell.sv
module stq_cell
   import stq_pkg::*;
(
   input  logic          clock,
   input  logic          valid,
   input  cell_cmd_type  cmd,
   input  cell_link_type left,
   input  cell_link_type right,
   output cell_link_type link
);

   entry_type entry_ff, entry_in;
   entry_type carry_ff, carry_in;
   logic      prior_ff, prior_in;
   logic      le;
   logic      hit;

   always_comb begin
      le       = valid && (entry_ff.deadline <= cmd.entry.deadline);
      hit      = valid && (entry_ff.id == cmd.tid);
      entry_in = entry_ff;
      prior_in = prior_ff;
      carry_in = carry_ff;
      case (cmd.op)
         CELL_CLEAR: begin
            prior_in = 1'b0;
         end
         CELL_SCAN: begin
            // pass the earliest match down the row
            prior_in = left.prior | hit;
            carry_in = left.prior ? left.carry : entry_ff;
         end
         CELL_REMOVE: begin
            if (prior_ff) begin
               entry_in = right.entry;
            end
         end
         CELL_POP: begin
            entry_in = right.entry;
         end
         CELL_INSERT: begin
            // keep if at or below the new deadline, else take the new or the left entry
            if (!le) begin
               entry_in = left.le ? cmd.entry : left.entry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      prior_ff <= prior_in;
      carry_ff <= carry_in;
   end

   assign link = '{entry: entry_ff, le: le, prior: prior_ff, carry: carry_ff};

endmodule

// File: hw/rtl/sorted_timer_queue.sv
// Path to rsp_valid: undefined codes, id zero and full insert go straight to the response
//   state; insert and tick pass their own state first; a lookup runs clear, scan, decide,
//   then remove on a hit and place for reset. A stalled response register adds its stall.
// Throughput: one transaction at a time, the next accepted from idle after the response
//   loads; the id search ripples one cell per cycle down the row and sets the lookup length.
// Reset: synchronous, active high; clears count, clock, next id (to one) and handshake state.
module sorted_timer_queue
   import stq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
   localparam int SCW  = $clog2(QUEUE_DEPTH);
   localparam logic [SCW-1:0]  SCAN_LAST = SCW'(QUEUE_DEPTH - 1);
   localparam logic [CNTW-1:0] COUNT_FULL = CNTW'(QUEUE_DEPTH);

   state_type       state_ff, state_in;
   req_type         req_ff, req_in;
   rsp_type         res_ff, res_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [15:0]     next_id_ff, next_id_in;
   logic [31:0]     clock_ff, clock_in;
   logic [SCW-1:0]  scan_ff, scan_in;

   cell_cmd_type    cmd;
   cell_link_type   links [QUEUE_DEPTH];
   cell_link_type   head_left;
   cell_link_type   tail_right;
   logic            hit;
   logic            due;
   logic            full;
   entry_type       found;

   // The left edge of the row always accepts a new entry; the right edge feeds
   // an entry that lands beyond the count and is never read.
   assign head_left  = '{entry: '0, le: 1'b1, prior: 1'b0, carry: '0};
   assign tail_right = '0;

   // Row of cells, slot 0 is the head (earliest deadline)
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      stq_cell u_cell (
         .clock (clock),
         .valid (CNTW'(k) < count_ff),
         .cmd   (cmd),
         .left  ((k == 0) ? head_left : links[(k == 0) ? 0 : k - 1]),
         .right ((k == QUEUE_DEPTH - 1) ? tail_right
                                        : links[(k == QUEUE_DEPTH - 1) ? k : k + 1]),
         .link  (links[k])
      );
   end

   assign hit   = links[QUEUE_DEPTH-1].prior;
   assign found = links[QUEUE_DEPTH-1].carry;
   assign full  = (count_ff == COUNT_FULL);
   // clock_ff has already advanced when the tick state runs
   assign due   = (count_ff != '0) && (links[0].entry.deadline < clock_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.func)
                  FUNC_INSERT: state_in = full ? ST_RESP : ST_INSERT;
                  FUNC_CANCEL, FUNC_RESET, FUNC_FIRE: begin
                     state_in = (req_data.timer_id == '0) ? ST_RESP : ST_CLEAR;
                  end
                  FUNC_TICK: state_in = ST_TICK;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_CLEAR:  state_in = ST_SCAN;
         ST_SCAN:   state_in = (scan_ff == SCAN_LAST) ? ST_DECIDE : ST_SCAN;
         ST_DECIDE: state_in = hit ? ST_REMOVE : ST_RESP;
         ST_REMOVE: state_in = (req_ff.func == FUNC_RESET) ? ST_PLACE : ST_RESP;
         ST_PLACE:  state_in = ST_RESP;
         ST_INSERT: state_in = ST_RESP;
         ST_TICK:   state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath updates
   always_comb begin
      cmd.op             = CELL_HOLD;
      cmd.tid            = req_ff.timer_id;
      cmd.entry.deadline = clock_ff + req_ff.delay_ms;
      cmd.entry.id       = next_id_ff;
      cmd.entry.handle   = req_ff.handle;
      req_in      = req_ff;
      res_in      = res_ff;
      count_in    = count_ff;
      next_id_in  = next_id_ff;
      clock_in    = clock_ff;
      scan_in     = scan_ff;
      req_stall   = (state_ff != ST_IDLE);
      // drop the held response once it is taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               res_in     = '0;
               res_in.status    = STATUS_NONE_DUE;
               res_in.occupancy = 5'(count_ff);
               case (req_data.func)
                  FUNC_INSERT: begin
                     if (full) begin
                        res_in.status = STATUS_FULL;
                     end
                  end
                  FUNC_CANCEL, FUNC_RESET, FUNC_FIRE: begin
                     if (req_data.timer_id == '0) begin
                        res_in.status = STATUS_NOT_FOUND;
                     end
                  end
                  FUNC_TICK: begin
                     clock_in = clock_ff + 32'd1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.op  = CELL_CLEAR;
            scan_in = '0;
         end
         ST_SCAN: begin
            cmd.op  = CELL_SCAN;
            scan_in = scan_ff + 1'b1;
         end
         ST_DECIDE: begin
            if (!hit) begin
               res_in.status = STATUS_NOT_FOUND;
            end
         end
         ST_REMOVE: begin
            // close the gap at the first match
            cmd.op           = CELL_REMOVE;
            count_in         = count_ff - 1'b1;
            res_in.status    = STATUS_OK;
            res_in.occupancy = 5'(count_ff - 1'b1);
            if (req_ff.func == FUNC_FIRE) begin
               res_in.fired      = 1'b1;
               res_in.out_id     = found.id;
               res_in.out_handle = found.handle;
            end
         end
         ST_PLACE: begin
            // re-sort the removed timer under its new deadline
            cmd.op           = CELL_INSERT;
            cmd.entry.id     = found.id;
            cmd.entry.handle = found.handle;
            count_in         = count_ff + 1'b1;
            res_in.occupancy = 5'(count_ff + 1'b1);
         end
         ST_INSERT: begin
            cmd.op           = CELL_INSERT;
            count_in         = count_ff + 1'b1;
            next_id_in       = (next_id_ff == ID_LAST) ? ID_FIRST : next_id_ff + 16'd1;
            res_in.status    = STATUS_OK;
            res_in.out_id    = next_id_ff;
            res_in.occupancy = 5'(count_ff + 1'b1);
         end
         ST_TICK: begin
            if (due) begin
               cmd.op            = CELL_POP;
               count_in          = count_ff - 1'b1;
               res_in.status     = STATUS_OK;
               res_in.fired      = 1'b1;
               res_in.out_id     = links[0].entry.id;
               res_in.out_handle = links[0].entry.handle;
               res_in.occupancy  = 5'(count_ff - 1'b1);
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         next_id_ff   <= ID_FIRST;
         clock_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         clock_ff     <= clock_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      scan_ff     <= scan_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("queue count above depth");

   a_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_id_ff != '0)
      else $error("next id is zero");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response raised outside response state");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the queue");
`endif

endmodule
